[hdl/gqs_pkg.sv]
// Package for the grid quantizer with strength: field widths, register codes
// and the structures passed between the pipeline modules.
// No dependencies.
package gqs_pkg;

	localparam int unsigned DATA_W = 32;  // sample, bounds, offset and result
	localparam int unsigned INTV_W = 31;  // grid interval register
	localparam int unsigned STR_W  = 17;  // strength register
	localparam int unsigned IDX_W  = 2;   // configuration register index
	localparam int unsigned NUM_W  = 35;  // signed numerator 2*d + q
	localparam int unsigned DVD_W  = 34;  // folded, non-negative dividend
	localparam int unsigned REM_W  = 32;  // partial remainder, below 2*q

	typedef enum logic [IDX_W-1:0] {
		REG_INTERVAL = 2'd0,
		REG_OFFSET   = 2'd1,
		REG_STRENGTH = 2'd2,
		REG_LIMIT    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [INTV_W-1:0]        interval;
		logic signed [DATA_W-1:0] offset;
		logic [STR_W-1:0]         strength;
		logic                     limit_en;
	} gqs_cfg_t;

	// Per-word side information that rides along the pipeline.
	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] lo;
		logic signed [DATA_W-1:0] hi;
		logic                     zero_err;
		logic                     neg;
	} gqs_ctx_t;

endpackage

[hdl/gqs_front.sv]
// Entry stage of the grid quantizer: offset removal and numerator folding.
// Depends on gqs_pkg.
module gqs_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             in_valid,
	input  logic signed [gqs_pkg::DATA_W-1:0] sample_value,
	input  logic signed [gqs_pkg::DATA_W-1:0] low_bound,
	input  logic signed [gqs_pkg::DATA_W-1:0] high_bound,
	input  gqs_pkg::gqs_cfg_t                cfg,
	output logic                             valid_s1,
	output gqs_pkg::gqs_ctx_t                ctx_s1,
	output logic [gqs_pkg::DVD_W-1:0]        dvd_s1
);
	import gqs_pkg::*;

	logic signed [DATA_W:0]  diff_c;
	logic signed [NUM_W-1:0] num_c;
	logic                    neg_c;
	logic [NUM_W-1:0]        fold_c;

	// The grid index is floor((2d + q) / 2q). A negative numerator is folded
	// to its ones complement so the divider only sees non-negative values;
	// the index is then the complement of the quotient.
	always_comb begin
		diff_c = $signed({sample_value[DATA_W-1], sample_value})
			- $signed({cfg.offset[DATA_W-1], cfg.offset});
		num_c  = $signed({diff_c[DATA_W], diff_c, 1'b0})
			+ $signed({{(NUM_W-INTV_W){1'b0}}, cfg.interval});
		neg_c  = num_c[NUM_W-1];
		fold_c = num_c ^ {NUM_W{neg_c}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s1.x        <= sample_value;
			ctx_s1.lo       <= low_bound;
			ctx_s1.hi       <= high_bound;
			ctx_s1.zero_err <= (cfg.interval == '0);
			ctx_s1.neg      <= neg_c;
			dvd_s1          <= fold_c[DVD_W-1:0];
		end
	end

endmodule

[hdl/gqs_div_step.sv]
// One restoring division step of the grid quantizer: one dividend bit per stage.
// Depends on gqs_pkg.
module gqs_div_step (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic [gqs_pkg::INTV_W-1:0] interval,
	input  logic                      valid_i,
	input  gqs_pkg::gqs_ctx_t         ctx_i,
	input  logic [gqs_pkg::REM_W-1:0] rem_i,
	input  logic [gqs_pkg::DVD_W-1:0] dvd_i,
	output logic                      valid_s1,
	output gqs_pkg::gqs_ctx_t         ctx_s1,
	output logic [gqs_pkg::REM_W-1:0] rem_s1,
	output logic [gqs_pkg::DVD_W-1:0] dvd_s1
);
	import gqs_pkg::*;

	logic [REM_W:0] divisor_c;
	logic [REM_W:0] trial_c;
	logic [REM_W:0] rem_c;

	// The divisor is twice the interval; the remainder always stays below it.
	always_comb begin
		divisor_c = {1'b0, interval, 1'b0};
		trial_c   = {rem_i, dvd_i[DVD_W-1]};
		rem_c     = (trial_c >= divisor_c) ? (trial_c - divisor_c) : trial_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s1 <= ctx_i;
			rem_s1 <= rem_c[REM_W-1:0];
			dvd_s1 <= {dvd_i[DVD_W-2:0], 1'b0};
		end
	end

endmodule

[hdl/gqs_back.sv]
// Back end of the grid quantizer: leftover distance, strength scaling,
// bound limiting and saturation, four register stages.
// Depends on gqs_pkg.
module gqs_back #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  gqs_pkg::gqs_cfg_t                 cfg,
	input  logic                              valid_i,
	input  gqs_pkg::gqs_ctx_t                 ctx_i,
	input  logic [gqs_pkg::REM_W-1:0]         rem_i,
	output logic                              valid_s4,
	output logic signed [gqs_pkg::DATA_W-1:0] value_s4,
	output logic                              err_s4
);
	import gqs_pkg::*;

	localparam int unsigned FX_W   = ((FRAC_BITS > STR_W) ? FRAC_BITS : STR_W) + 2;
	localparam int unsigned PROD_W = DATA_W + FX_W;
	localparam int unsigned RES_W  = PROD_W + 2;
	localparam logic [FX_W-1:0] ONE_V = {{(FX_W-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic signed [PROD_W:0] HALF_V =
		{{PROD_W{1'b0}}, 1'b1} << (FRAC_BITS - 1);

	// Stage 1: leftover distance e from the division remainder.
	logic signed [DATA_W:0]   two_e_c;
	logic signed [FX_W-1:0]   factor_c;
	logic                     valid_s1;
	gqs_ctx_t                 ctx_s1;
	logic signed [DATA_W-1:0] e_s1;
	logic signed [FX_W-1:0]   factor_s1;

	always_comb begin
		if (ctx_i.neg) begin
			two_e_c = $signed({2'b00, cfg.interval}) - $signed({{DATA_W{1'b0}}, 1'b1})
				- $signed({1'b0, rem_i});
		end else begin
			two_e_c = $signed({1'b0, rem_i}) - $signed({2'b00, cfg.interval});
		end
		factor_c = $signed(ONE_V) - $signed({{(FX_W-STR_W){1'b0}}, cfg.strength});
	end

	// Stage 2: e times (1 - strength).
	logic                     valid_s2;
	gqs_ctx_t                 ctx_s2;
	logic signed [DATA_W-1:0] e_s2;
	logic signed [PROD_W-1:0] prod_s2;

	// Stage 3: rounded leftover and the unlimited result x - e + leftover.
	logic signed [PROD_W:0]  sum_c;
	logic signed [PROD_W:0]  leftover_c;
	logic signed [RES_W-1:0] base_c;
	logic                    valid_s3;
	gqs_ctx_t                ctx_s3;
	logic signed [RES_W-1:0] base_s3;

	always_comb begin
		sum_c      = $signed({prod_s2[PROD_W-1], prod_s2}) + HALF_V;
		leftover_c = sum_c >>> FRAC_BITS;
		base_c     = $signed({{(RES_W-DATA_W){ctx_s2.x[DATA_W-1]}}, ctx_s2.x})
			- $signed({{(RES_W-DATA_W){e_s2[DATA_W-1]}}, e_s2})
			+ $signed({leftover_c[PROD_W], leftover_c});
	end

	// Stage 4: bound limiting and saturation.
	logic signed [RES_W-1:0] q_c;
	logic signed [RES_W-1:0] up_c;
	logic signed [RES_W-1:0] final_c;
	logic                    ovf_hi_c;
	logic                    ovf_lo_c;
	logic signed [DATA_W-1:0] sat_c;

	always_comb begin
		q_c  = $signed({{(RES_W-INTV_W){1'b0}}, cfg.interval});
		up_c = (cfg.limit_en && (base_s3 < $signed({{(RES_W-DATA_W){ctx_s3.lo[DATA_W-1]}},
			ctx_s3.lo}))) ? (base_s3 + q_c) : base_s3;
		final_c = (cfg.limit_en && (up_c > $signed({{(RES_W-DATA_W){ctx_s3.hi[DATA_W-1]}},
			ctx_s3.hi}))) ? (base_s3 - q_c) : up_c;
		ovf_hi_c = !final_c[RES_W-1] && (|final_c[RES_W-2:DATA_W-1]);
		ovf_lo_c = final_c[RES_W-1] && !(&final_c[RES_W-2:DATA_W-1]);
		if (ctx_s3.zero_err) begin
			sat_c = '0;
		end else if (ovf_hi_c) begin
			sat_c = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (ovf_lo_c) begin
			sat_c = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sat_c = final_c[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s1    <= ctx_i;
			e_s1      <= two_e_c[DATA_W:1];
			factor_s1 <= factor_c;
			ctx_s2    <= ctx_s1;
			e_s2      <= e_s1;
			prod_s2   <= $signed({{FX_W{e_s1[DATA_W-1]}}, e_s1})
				* $signed({{DATA_W{factor_s1[FX_W-1]}}, factor_s1});
			ctx_s3    <= ctx_s2;
			base_s3   <= base_c;
			value_s4  <= sat_c;
			err_s4    <= ctx_s3.zero_err;
		end
	end

endmodule

[hdl/grid_quantizer_with_strength_core.sv]
// Top level of the grid quantizer with strength: configuration registers,
// entry stage, pipelined divider and back end.
// Depends on gqs_pkg, gqs_front, gqs_div_step and gqs_back.
//
//   Channel  Direction  Handshake               Payload
//   in       to core    in_valid / in_stall     sample_value, low_bound, high_bound
//   out      from core  out_valid / out_stall   quantized_value, zero_interval_error
//   cfg      to core    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// The core takes one word per cycle while the pipeline is not held, passing
// it through one entry stage, 34 restoring divider stages (one dividend bit
// each) and four back-end stages. Reset clears every valid bit and loads the
// register defaults. While a result waits on out_stall the whole pipeline holds
// and in_stall is raised; nothing inside is dropped or repeated. Configuration
// writes are always taken (cfg_ready is tied high).
module grid_quantizer_with_strength_core #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [gqs_pkg::DATA_W-1:0] sample_value,
	input  logic signed [gqs_pkg::DATA_W-1:0] low_bound,
	input  logic signed [gqs_pkg::DATA_W-1:0] high_bound,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [gqs_pkg::DATA_W-1:0] quantized_value,
	output logic                              zero_interval_error,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gqs_pkg::IDX_W-1:0]         cfg_index,
	input  logic [gqs_pkg::DATA_W-1:0]        cfg_data
);
	import gqs_pkg::*;

	localparam logic [INTV_W-1:0] INTV_RST = {{(INTV_W-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [STR_W-1:0]  STR_RST  = {{(STR_W-1){1'b0}}, 1'b1} << FRAC_BITS;

	gqs_cfg_t cfg_q;
	logic     adv;

	// The pipeline moves whenever the output register is empty or being read.
	assign adv       = !(out_valid && out_stall);
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;

	// Configuration registers; extra high bits of the data word are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval <= INTV_RST;
			cfg_q.offset   <= '0;
			cfg_q.strength <= STR_RST;
			cfg_q.limit_en <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_INTERVAL: cfg_q.interval <= cfg_data[INTV_W-1:0];
				REG_OFFSET:   cfg_q.offset   <= cfg_data;
				REG_STRENGTH: cfg_q.strength <= cfg_data[STR_W-1:0];
				REG_LIMIT:    cfg_q.limit_en <= cfg_data[0];
				default:      cfg_q.limit_en <= cfg_q.limit_en;
			endcase
		end
	end

	// Stage chain: index 0 is the entry stage, index k the k-th divider step.
	logic                 valid_a [0:DVD_W];
	gqs_ctx_t             ctx_a   [0:DVD_W];
	logic [REM_W-1:0]     rem_a   [0:DVD_W];
	logic [DVD_W-1:0]     dvd_a   [0:DVD_W];

	gqs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_valid     (in_valid),
		.sample_value (sample_value),
		.low_bound    (low_bound),
		.high_bound   (high_bound),
		.cfg          (cfg_q),
		.valid_s1     (valid_a[0]),
		.ctx_s1       (ctx_a[0]),
		.dvd_s1       (dvd_a[0])
	);

	// The partial remainder starts at zero ahead of the first divider step.
	assign rem_a[0] = '0;

	for (genvar k = 0; k < DVD_W; k++) begin : g_div
		gqs_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.interval (cfg_q.interval),
			.valid_i  (valid_a[k]),
			.ctx_i    (ctx_a[k]),
			.rem_i    (rem_a[k]),
			.dvd_i    (dvd_a[k]),
			.valid_s1 (valid_a[k+1]),
			.ctx_s1   (ctx_a[k+1]),
			.rem_s1   (rem_a[k+1]),
			.dvd_s1   (dvd_a[k+1])
		);
	end

	// The final dividend shift is not needed past the last step, but the
	// remainder is: it gives the leftover distance without a multiplier.
	gqs_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.cfg      (cfg_q),
		.valid_i  (valid_a[DVD_W]),
		.ctx_i    (ctx_a[DVD_W]),
		.rem_i    (rem_a[DVD_W] ^ {REM_W{dvd_a[DVD_W][0]}}),
		.valid_s4 (out_valid),
		.value_s4 (quantized_value),
		.err_s4   (zero_interval_error)
	);

endmodule

[tb/sv/gqs_result_checker.sv]
// Checker for the grid quantizer with strength: tracks the register writes,
// predicts one result word per accepted input word and compares in order.
// Depends on gqs_pkg.
`timescale 1ns / 1ps

module gqs_result_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic signed [gqs_pkg::DATA_W-1:0] sample_value,
	input  logic signed [gqs_pkg::DATA_W-1:0] low_bound,
	input  logic signed [gqs_pkg::DATA_W-1:0] high_bound,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [gqs_pkg::DATA_W-1:0] quantized_value,
	input  logic                              zero_interval_error,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [gqs_pkg::IDX_W-1:0]         cfg_index,
	input  logic [gqs_pkg::DATA_W-1:0]        cfg_data,
	output int                                fail_count,
	output int                                words_in_flight
);
	import gqs_pkg::*;

	localparam int    FRAC_BITS = 16;
	localparam longint FX_ONE   = longint'(1) << FRAC_BITS;
	localparam longint FX_HALF  = longint'(1) << (FRAC_BITS - 1);
	localparam longint SAT_HI   = 64'sd2147483647;
	localparam longint SAT_LO   = -64'sd2147483648;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     zero_err;
	} quant_word_t;

	logic [INTV_W-1:0]        grid_step;
	logic signed [DATA_W-1:0] grid_origin;
	logic [STR_W-1:0]         pull;
	logic                     limit_on;

	quant_word_t predicted_words [$];

	function automatic longint floor_quot(input longint a, input longint b);
		longint quo;
		quo = a / b;
		if ((a % b) != 0 && a < 0) begin
			quo = quo - 1;
		end
		return quo;
	endfunction

	function automatic quant_word_t quantize_sample(input logic signed [DATA_W-1:0] x,
			input logic signed [DATA_W-1:0] lo, input logic signed [DATA_W-1:0] hi);
		quant_word_t w;
		longint step, delta, idx, rest, scaled, res;
		w.value = '0;
		w.zero_err = 1'b0;
		step = longint'(grid_step);
		if (step == 0) begin
			w.zero_err = 1'b1;
			return w;
		end
		delta = longint'(x) - longint'(grid_origin);
		idx = floor_quot(2 * delta + step, 2 * step);
		rest = delta - idx * step;
		scaled = floor_quot(rest * (FX_ONE - longint'(pull)) + FX_HALF, FX_ONE);
		res = longint'(grid_origin) + idx * step + scaled;
		// The high test looks at the result left by the low test.
		if (limit_on) begin
			if (res < longint'(lo)) begin
				res = longint'(grid_origin) + (idx + 1) * step + scaled;
			end
			if (res > longint'(hi)) begin
				res = longint'(grid_origin) + (idx - 1) * step + scaled;
			end
		end
		if (res > SAT_HI) begin
			res = SAT_HI;
		end else if (res < SAT_LO) begin
			res = SAT_LO;
		end
		w.value = res[DATA_W-1:0];
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		quant_word_t want;
		if (!arst_n) begin
			predicted_words.delete();
			grid_step = INTV_W'(32'h0001_0000);
			grid_origin = '0;
			pull = STR_W'(32'h0001_0000);
			limit_on = 1'b0;
			fail_count = 0;
			words_in_flight = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (predicted_words.size() == 0) begin
					$error("quantized_value: expected no word, got %0d", quantized_value);
					fail_count++;
				end else begin
					want = predicted_words.pop_front();
					if (quantized_value !== want.value) begin
						$error("quantized_value: expected %0d, got %0d",
							want.value, quantized_value);
						fail_count++;
					end
					if (zero_interval_error !== want.zero_err) begin
						$error("zero_interval_error: expected %0d, got %0d",
							want.zero_err, zero_interval_error);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				predicted_words.push_back(quantize_sample(sample_value, low_bound, high_bound));
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_INTERVAL: grid_step = cfg_data[INTV_W-1:0];
					REG_OFFSET:   grid_origin = cfg_data;
					REG_STRENGTH: pull = cfg_data[STR_W-1:0];
					REG_LIMIT:    limit_on = cfg_data[0];
					default: ;
				endcase
			end
			words_in_flight = predicted_words.size();
		end
	end

endmodule

[tb/sv/tb_grid_quantizer_with_strength_core.sv]
// Testbench top for the grid quantizer with strength: clock, reset, register
// programming, input words and output pacing; gives the verdict.
// Depends on gqs_pkg, grid_quantizer_with_strength_core and gqs_result_checker.
`timescale 1ns / 1ps

module tb_grid_quantizer_with_strength_core;
	import gqs_pkg::*;

	// The core takes a word every cycle while its output is not stalled, so the
	// run is mostly bounded by the random gaps and stalls and the drains before
	// each register write; this limit leaves a wide margin over that.
	localparam int unsigned CYCLE_LIMIT  = 100000;
	localparam int unsigned DRAIN_CYCLES = 60;
	localparam int unsigned PHASES       = 10;
	localparam int unsigned PHASE_WORDS  = 50;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [DATA_W-1:0] sample_value;
	logic signed [DATA_W-1:0] low_bound;
	logic signed [DATA_W-1:0] high_bound;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] quantized_value;
	logic                     zero_interval_error;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [IDX_W-1:0]         cfg_index;
	logic [DATA_W-1:0]        cfg_data;
	int                       fail_count;
	int                       words_in_flight;

	// When calm is set neither side inserts gaps, so the pipeline runs full.
	bit                       calm;

	// Copy of the programmed grid, used only to aim the random samples at it.
	int unsigned              cur_interval;
	logic signed [DATA_W-1:0] cur_offset;

	int unsigned              cycle_count = 0;

	grid_quantizer_with_strength_core i_dut (.*);

	gqs_result_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// A hard stop in case a word is lost or the handshake hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_grid_quantizer_with_strength_core: FAIL");
			$finish;
		end
	end

	// Random value within span of base, wrapping at 32 bits. The span is kept
	// at or below 2^30 by the callers so the range fits in 32 bits.
	function automatic logic signed [DATA_W-1:0] jittered(input logic signed [DATA_W-1:0] base,
			input int unsigned span);
		longint jit;
		jit = longint'($urandom_range(2 * span, 0)) - longint'(span);
		return base + DATA_W'(jit);
	endfunction

	// Send one input word. The task is entered and left at a falling edge;
	// valid stays high on exit so that back-to-back words need no toggle.
	task automatic send_sample(input logic signed [DATA_W-1:0] x,
			input logic signed [DATA_W-1:0] lo, input logic signed [DATA_W-1:0] hi);
		int unsigned gap;
		bit took;
		gap = calm ? 0 : $urandom_range(4, 0);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		sample_value <= x;
		low_bound <= lo;
		high_bound <= hi;
		in_valid <= 1'b1;
		do begin
			@(posedge clk);
			took = !in_stall;
			@(negedge clk);
		end while (!took);
	endtask

	// Drop valid and wait until every predicted word has come back, so the
	// core is idle. Every input word makes a result, so nothing is left
	// working inside once the checker's queue is empty.
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (words_in_flight != 0) begin
			@(negedge clk);
		end
	endtask

	// Write all four registers back to back. The raw data words may carry
	// bits above each register's width; the core must ignore them.
	task automatic program_regs(input logic [DATA_W-1:0] intv_d, input logic [DATA_W-1:0] offs_d,
			input logic [DATA_W-1:0] str_d, input logic [DATA_W-1:0] lim_d);
		logic [DATA_W-1:0] data [4];
		cfg_reg_t order [4];
		bit took;
		data = '{intv_d, offs_d, str_d, lim_d};
		order = '{REG_INTERVAL, REG_OFFSET, REG_STRENGTH, REG_LIMIT};
		settle();
		for (int i = 0; i < 4; i++) begin
			cfg_index <= order[i];
			cfg_data <= data[i];
			cfg_valid <= 1'b1;
			do begin
				@(posedge clk);
				took = cfg_ready;
				@(negedge clk);
			end while (!took);
		end
		cfg_valid <= 1'b0;
		cur_interval = 32'(intv_d[INTV_W-1:0]);
		cur_offset = offs_d;
	endtask

	// Output pacing: before each result word the receiver holds stall for a
	// random number of cycles, then lowers it until a word is taken.
	initial begin
		int unsigned hold;
		bit took;
		out_stall = 1'b0;
		@(negedge clk);
		forever begin
			hold = calm ? 0 : $urandom_range(4, 0);
			repeat (hold) begin
				out_stall <= 1'b1;
				@(negedge clk);
			end
			out_stall <= 1'b0;
			do begin
				@(posedge clk);
				took = out_valid && !out_stall;
				@(negedge clk);
			end while (!took);
		end
	end

	initial begin
		int k;
		int unsigned span, xmode, bmode, pick;
		logic signed [DATA_W-1:0] x, lo, hi;
		logic [DATA_W-1:0] intv_d, offs_d, str_d;

		in_valid = 1'b0;
		sample_value = '0;
		low_bound = '0;
		high_bound = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_INTERVAL;
		cfg_data = '0;
		calm = 1'b0;
		cur_interval = 32'h0001_0000;
		cur_offset = '0;

		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Register defaults after reset: unit grid, full snap, no limiting.
		// A half step rounds up, just below half rounds down, and the top
		// of the range rounds up to 2^31 and must saturate.
		send_sample(32'sd0, 32'sd0, 32'sd0);
		send_sample(32'sh0000_7FFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_sample(32'sh0000_8000, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_sample(-32'sd32768, 32'sd0, 32'sd0);
		send_sample(-32'sd32769, 32'sd0, 32'sd0);
		send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);

		// Zero interval, written with its unused top bit set: error flag and a
		// zero result whatever the sample.
		program_regs(32'h8000_0000, 32'h1234_5678, 32'hABCD_8000, 32'hFFFF_FFFE);
		send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);

		// Widest grid at the lowest origin with no attraction: the leftover is
		// kept whole, so the sample comes back through the full datapath.
		program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
		send_sample(32'sh7FFF_FFFF, 32'sd0, 32'sd0);
		send_sample(32'sh8000_0000, 32'sd0, 32'sd0);
		send_sample(32'sd0, 32'sd0, 32'sd0);

		// Highest origin and the largest strength the register holds, which
		// is above one and pushes values away from the grid; limiting on.
		program_regs(32'h0001_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
		send_sample(32'sd0, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_sample(32'sh0000_8000, 32'sh8000_0000, 32'sh7FFF_FFFF);

		// Unit grid with limiting: both bounds crossed, low only, high only,
		// inside, and both ends of the range, where a bound shift moves the result inward.
		program_regs(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0001);
		send_sample(32'sd0, 32'sd1, 32'sd0);
		send_sample(32'sd0, 32'sd10, 32'sh7FFF_FFFF);
		send_sample(32'sd0, 32'sh8000_0000, -32'sd10);
		send_sample(32'sd0, -32'sd1, 32'sd1);
		send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);

		// Odd tiny grid at half strength: the scaled leftover lands exactly
		// on a half and must round toward plus infinity.
		program_regs(32'h0000_0003, 32'h0000_0000, 32'h0000_8000, 32'h0000_0000);
		send_sample(32'sd1, 32'sd0, 32'sd0);
		send_sample(-32'sd1, 32'sd0, 32'sd0);
		send_sample(-32'sd2, 32'sd0, 32'sd0);

		// Random phases: a fresh register setting each time, then words aimed
		// mostly at grid points, ties and nearby bounds, with some noise.
		for (int p = 0; p < PHASES; p++) begin
			intv_d = $urandom;
			pick = $urandom_range(9, 0);
			case (pick)
				0: intv_d[INTV_W-1:0] = '0;
				1: intv_d[INTV_W-1:0] = '1;
				2: ;
				3: intv_d[INTV_W-1:0] = 31'd1;
				default: intv_d[INTV_W-1:0] = 31'($urandom_range(32'h0004_0000, 1));
			endcase
			pick = $urandom_range(5, 0);
			case (pick)
				0: offs_d = 32'h8000_0000;
				1: offs_d = 32'h7FFF_FFFF;
				2, 3: offs_d = $urandom;
				default: offs_d = jittered(32'sd0, 32'h0008_0000);
			endcase
			str_d = $urandom;
			pick = $urandom_range(5, 0);
			case (pick)
				0: str_d[STR_W-1:0] = '0;
				1: str_d[STR_W-1:0] = 17'h1_0000;
				2: ;
				3: str_d[STR_W-1:0] = '1;
				default: str_d[STR_W-1:0] = 17'($urandom_range(32'h0001_0000, 0));
			endcase
			program_regs(intv_d, offs_d, str_d, $urandom);
			calm = (p % 4 == 3);

			if (cur_interval == 0) begin
				span = 32'h0001_0000;
			end else if (cur_interval > 32'h2000_0000) begin
				span = 32'h4000_0000;
			end else begin
				span = 2 * cur_interval;
			end

			repeat (PHASE_WORDS) begin
				k = int'($urandom_range(64, 0)) - 32;
				xmode = $urandom_range(9, 0);
				case (xmode)
					0, 1: x = $urandom;
					// Half way between two grid points, rounded down for an odd interval.
					2: x = cur_offset + DATA_W'(longint'(k) * longint'(cur_interval)
						+ longint'(cur_interval / 2));
					3, 4, 5, 6: x = jittered(cur_offset
						+ DATA_W'(longint'(k) * longint'(cur_interval)), span / 2);
					default: x = jittered(32'sd0, 32'h0004_0000);
				endcase
				bmode = $urandom_range(9, 0);
				case (bmode)
					0, 1: begin
						lo = $urandom;
						hi = $urandom;
					end
					2: begin
						lo = 32'sh8000_0000;
						hi = 32'sh7FFF_FFFF;
					end
					// Bounds close to the sample cross it from either side,
					// and sometimes both at once when they come out inverted.
					default: begin
						lo = jittered(x, span);
						hi = jittered(x, span);
					end
				endcase
				send_sample(x, lo, hi);
			end
		end

		calm = 1'b0;
		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("tb_grid_quantizer_with_strength_core: PASS");
		end else begin
			$display("tb_grid_quantizer_with_strength_core: FAIL");
		end
		$finish;
	end

endmodule
